// ----- rtl/jrkv_pkg.sv -----
package jrkv_pkg;

    typedef enum logic [2:0] {
        PH_SCAN,
        PH_PRE,
        PH_BODY,
        PH_RUN,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        CFG_KEY_BYTES  = 2'd0,
        CFG_KEY_LENGTH = 2'd1,
        CFG_VALUE_MODE = 2'd2,
        CFG_CAPACITY   = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] MODE_INT = 2'd0;
    localparam logic [1:0] MODE_STR = 2'd1;
    localparam logic [1:0] MODE_ARR = 2'd2;

    localparam int CFG_DATA_W = 64;
    localparam int KEY_LEN_W  = 4;
    localparam int CAP_W      = 16;
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;

    localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = 4'd1;
    localparam logic [CAP_W-1:0]     CAPACITY_RST   = 16'd16;
    localparam logic [VALUE_W-1:0]   ELEM_MAX       = 32'd65535;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    typedef struct packed {
        logic [KEY_LEN_W-1:0] key_length;
        logic [1:0]           value_mode;
        logic [CAP_W-1:0]     capacity;
    } t_cfg;

    typedef struct packed {
        logic                      has_item;
        logic signed [VALUE_W-1:0] value_int;
        logic [CHAR_W-1:0]         char_out;
        logic                      found;
        logic [CAP_W-1:0]          item_count;
        logic                      last;
    } t_result;

    function automatic logic is_ws4(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic [VALUE_W-1:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return {24'd0, d};
    endfunction

    function automatic logic [VALUE_W-1:0] mac10(input logic [VALUE_W-1:0] acc,
                                                 input logic [7:0] c);
        return (acc << 3) + (acc << 1) + digit_val(c);
    endfunction

endpackage

// ----- rtl/jrkv_fifo.sv -----
module jrkv_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push_a,
    input  logic                         i_push_b,
    input  jrkv_pkg::t_result            i_res_a,
    input  jrkv_pkg::t_result            i_res_b,
    input  logic                         i_pop,
    output logic                         o_valid,
    output jrkv_pkg::t_result            o_res,
    output logic [jrkv_pkg::OUT_CNT_W-1:0] o_count
);

    jrkv_pkg::t_result r_mem [jrkv_pkg::OUT_DEPTH];
    logic [jrkv_pkg::OUT_PTR_W-1:0] r_wp, n_wp;
    logic [jrkv_pkg::OUT_PTR_W-1:0] r_rp, n_rp;
    logic [jrkv_pkg::OUT_CNT_W-1:0] r_count, n_count;
    logic [jrkv_pkg::OUT_PTR_W-1:0] wp_b;
    logic                           pop_ok;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign o_count = r_count;
    assign pop_ok  = i_pop && o_valid;
    assign wp_b    = r_wp + jrkv_pkg::OUT_PTR_W'(1);

    always_comb begin
        n_wp    = r_wp + jrkv_pkg::OUT_PTR_W'(i_push_a) + jrkv_pkg::OUT_PTR_W'(i_push_b);
        n_rp    = r_rp + jrkv_pkg::OUT_PTR_W'(pop_ok);
        n_count = r_count + jrkv_pkg::OUT_CNT_W'(i_push_a) + jrkv_pkg::OUT_CNT_W'(i_push_b)
                  - jrkv_pkg::OUT_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wp] <= i_res_a;
        end
        if (i_push_b) begin
            r_mem[wp_b] <= i_res_b;
        end
    end

endmodule

// ----- rtl/jrkv_core.sv -----
module jrkv_core #(
    parameter int KEY_BYTES  = 8,
    parameter int DEPTH_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [7:0]             i_byte_in,
    input  logic                   i_msg_end,
    input  logic [8*KEY_BYTES-1:0] i_key,
    input  jrkv_pkg::t_cfg         i_cfg,
    output logic                   o_busy,
    output logic                   o_push_a,
    output logic                   o_push_b,
    output jrkv_pkg::t_result      o_res_a,
    output jrkv_pkg::t_result      o_res_b
);

    localparam logic [jrkv_pkg::KEY_LEN_W-1:0] KEY_MAX = jrkv_pkg::KEY_LEN_W'(KEY_BYTES);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    // input stage
    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_end;

    // message state
    logic [DEPTH_BITS-1:0]             r_depth, n_depth;
    logic                              r_in_str, n_in_str;
    logic                              r_esc, n_esc;
    logic [jrkv_pkg::KEY_LEN_W-1:0]    r_kpos, n_kpos;
    logic                              r_kmatch, n_kmatch;
    logic                              r_await, n_await;
    jrkv_pkg::t_phase                  r_phase, n_phase;
    logic [jrkv_pkg::VALUE_W-1:0]      r_acc, n_acc;
    logic                              r_neg, n_neg;
    logic [jrkv_pkg::CAP_W-1:0]        r_cnt, n_cnt;

    logic [1:0]                     mode;
    logic [jrkv_pkg::KEY_LEN_W-1:0] klen;
    logic [7:0]                     kc;
    logic                           kc_ok;
    logic [jrkv_pkg::CAP_W-1:0]     cnt_inc;
    logic                           room_str;
    logic                           room_arr;
    logic                           elem_ok;

    assign o_busy   = r_vld;
    assign mode     = (i_cfg.value_mode == 2'd3) ? jrkv_pkg::MODE_INT : i_cfg.value_mode;
    assign klen     = (i_cfg.key_length > KEY_MAX) ? KEY_MAX : i_cfg.key_length;
    assign cnt_inc  = r_cnt + jrkv_pkg::CAP_W'(1);
    assign room_str = ({1'b0, r_cnt} + 17'd1) < {1'b0, i_cfg.capacity};
    assign room_arr = r_cnt < i_cfg.capacity;
    assign elem_ok  = (r_acc != '0) && (r_acc <= jrkv_pkg::ELEM_MAX);
    assign kc_ok    = (kc != 8'd0) && (kc != jrkv_pkg::CH_QUOTE) && (kc != jrkv_pkg::CH_BSLASH);

    always_comb begin
        kc = 8'd0;
        for (int k = 0; k < KEY_BYTES; k++) begin
            if (r_kpos[2:0] == 3'(k)) begin
                kc = i_key[8*k +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte_in;
            r_end  <= i_msg_end;
        end
    end

    always_comb begin
        logic [7:0]                   c;
        logic                         do_scan;
        logic [jrkv_pkg::VALUE_W-1:0] v;
        jrkv_pkg::t_result            elem;
        jrkv_pkg::t_result            fin;
        logic                         has_elem;
        logic [jrkv_pkg::CAP_W-1:0]   cnt_fin;

        c        = r_byte;
        do_scan  = 1'b0;
        v        = '0;
        elem     = '0;
        fin      = '0;
        has_elem = 1'b0;
        cnt_fin  = r_cnt;

        n_depth  = r_depth;
        n_in_str = r_in_str;
        n_esc    = r_esc;
        n_kpos   = r_kpos;
        n_kmatch = r_kmatch;
        n_await  = r_await;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        o_push_a = 1'b0;
        o_push_b = 1'b0;
        o_res_a  = '0;
        o_res_b  = '0;

        if (r_vld && r_end) begin
            if (mode == jrkv_pkg::MODE_ARR && r_phase == jrkv_pkg::PH_RUN
                    && elem_ok && room_arr) begin
                has_elem       = 1'b1;
                cnt_fin        = cnt_inc;
                elem.has_item  = 1'b1;
                elem.value_int = r_acc;
            end
            if (mode == jrkv_pkg::MODE_STR && r_phase == jrkv_pkg::PH_BODY
                    && r_esc && room_str) begin
                has_elem      = 1'b1;
                cnt_fin       = cnt_inc;
                elem.has_item = 1'b1;
                elem.char_out = jrkv_pkg::CH_BSLASH;
            end
            elem.found      = 1'b1;
            elem.item_count = cnt_fin;

            v = r_neg ? (32'd0 - r_acc) : r_acc;
            if (r_phase == jrkv_pkg::PH_SCAN || r_phase == jrkv_pkg::PH_PRE) begin
                v = '0;
            end
            fin.has_item   = (mode == jrkv_pkg::MODE_INT);
            fin.value_int  = (mode == jrkv_pkg::MODE_INT) ? v : '0;
            fin.found      = (r_phase != jrkv_pkg::PH_SCAN);
            fin.item_count = cnt_fin;
            fin.last       = 1'b1;

            o_push_a = 1'b1;
            if (has_elem) begin
                o_res_a  = elem;
                o_res_b  = fin;
                o_push_b = 1'b1;
            end else begin
                o_res_a = fin;
            end

            n_depth  = '0;
            n_in_str = 1'b0;
            n_esc    = 1'b0;
            n_kpos   = '0;
            n_kmatch = 1'b0;
            n_await  = 1'b0;
            n_phase  = jrkv_pkg::PH_SCAN;
            n_acc    = '0;
            n_neg    = 1'b0;
            n_cnt    = '0;
        end else if (r_vld) begin
            o_res_a.has_item   = 1'b1;
            o_res_a.found      = 1'b1;
            o_res_a.item_count = cnt_inc;
            case (r_phase)
                jrkv_pkg::PH_SCAN: begin
                    if (r_await) begin
                        if (!jrkv_pkg::is_ws4(c)) begin
                            n_await = 1'b0;
                            if (c == jrkv_pkg::CH_COLON) begin
                                n_phase  = jrkv_pkg::PH_PRE;
                                n_esc    = 1'b0;
                                n_in_str = 1'b0;
                                n_kmatch = 1'b0;
                                n_acc    = '0;
                                n_neg    = 1'b0;
                            end else begin
                                do_scan = 1'b1;
                            end
                        end
                    end else begin
                        do_scan = 1'b1;
                    end
                    if (do_scan) begin
                        if (r_in_str) begin
                            if (r_kmatch) begin
                                if (r_kpos < klen) begin
                                    if (kc_ok && c == kc) begin
                                        n_kpos = r_kpos + jrkv_pkg::KEY_LEN_W'(1);
                                    end else begin
                                        n_kmatch = 1'b0;
                                    end
                                end else begin
                                    n_kmatch = 1'b0;
                                    if (c == jrkv_pkg::CH_QUOTE) begin
                                        n_await = 1'b1;
                                    end
                                end
                            end
                            if (r_esc) begin
                                n_esc = 1'b0;
                            end else if (c == jrkv_pkg::CH_BSLASH) begin
                                n_esc = 1'b1;
                            end else if (c == jrkv_pkg::CH_QUOTE) begin
                                n_in_str = 1'b0;
                            end
                        end else if (c == jrkv_pkg::CH_QUOTE) begin
                            n_in_str = 1'b1;
                            if (r_depth == DEPTH_ONE) begin
                                n_kmatch = 1'b1;
                                n_kpos   = '0;
                            end
                        end else if (c == jrkv_pkg::CH_LBRACE || c == jrkv_pkg::CH_LBRACK) begin
                            if (r_depth != DEPTH_MAX) begin
                                n_depth = r_depth + DEPTH_ONE;
                            end
                        end else if (c == jrkv_pkg::CH_RBRACE || c == jrkv_pkg::CH_RBRACK) begin
                            if (r_depth != '0) begin
                                n_depth = r_depth - DEPTH_ONE;
                            end
                        end
                    end
                end
                jrkv_pkg::PH_PRE: begin
                    if (mode == jrkv_pkg::MODE_INT) begin
                        if (jrkv_pkg::is_ws4(c) || c == jrkv_pkg::CH_VT
                                || c == jrkv_pkg::CH_FF) begin
                            n_phase = r_phase;
                        end else if (c == jrkv_pkg::CH_PLUS) begin
                            n_phase = jrkv_pkg::PH_BODY;
                        end else if (c == jrkv_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = jrkv_pkg::PH_BODY;
                        end else if (jrkv_pkg::is_digit(c)) begin
                            n_acc   = jrkv_pkg::digit_val(c);
                            n_phase = jrkv_pkg::PH_BODY;
                        end else begin
                            n_phase = jrkv_pkg::PH_DONE;
                        end
                    end else if (!jrkv_pkg::is_ws4(c)) begin
                        if (c == ((mode == jrkv_pkg::MODE_STR) ? jrkv_pkg::CH_QUOTE
                                                                : jrkv_pkg::CH_LBRACK)) begin
                            n_phase = jrkv_pkg::PH_BODY;
                        end else begin
                            n_phase = jrkv_pkg::PH_DONE;
                        end
                    end
                end
                jrkv_pkg::PH_BODY: begin
                    if (mode == jrkv_pkg::MODE_INT) begin
                        if (jrkv_pkg::is_digit(c)) begin
                            n_acc = jrkv_pkg::mac10(r_acc, c);
                        end else begin
                            n_phase = jrkv_pkg::PH_DONE;
                        end
                    end else if (mode == jrkv_pkg::MODE_STR) begin
                        if (!r_esc && c == jrkv_pkg::CH_QUOTE) begin
                            n_phase = jrkv_pkg::PH_DONE;
                        end else if (!r_esc && c == jrkv_pkg::CH_BSLASH) begin
                            n_esc = 1'b1;
                        end else begin
                            n_esc = 1'b0;
                            if (room_str) begin
                                n_cnt            = cnt_inc;
                                o_push_a         = 1'b1;
                                o_res_a.char_out = c;
                            end
                        end
                    end else begin
                        if (c == jrkv_pkg::CH_RBRACK) begin
                            n_phase = jrkv_pkg::PH_DONE;
                        end else if (jrkv_pkg::is_digit(c)) begin
                            n_acc   = jrkv_pkg::digit_val(c);
                            n_phase = jrkv_pkg::PH_RUN;
                        end
                    end
                end
                jrkv_pkg::PH_RUN: begin
                    if (jrkv_pkg::is_digit(c)) begin
                        n_acc = jrkv_pkg::mac10(r_acc, c);
                    end else begin
                        if (elem_ok && room_arr) begin
                            n_cnt             = cnt_inc;
                            o_push_a          = 1'b1;
                            o_res_a.value_int = r_acc;
                        end
                        n_acc = '0;
                        if (c == jrkv_pkg::CH_RBRACK || n_cnt >= i_cfg.capacity) begin
                            n_phase = jrkv_pkg::PH_DONE;
                        end else begin
                            n_phase = jrkv_pkg::PH_BODY;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
            r_kpos   <= '0;
            r_kmatch <= 1'b0;
            r_await  <= 1'b0;
            r_phase  <= jrkv_pkg::PH_SCAN;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
            r_kpos   <= n_kpos;
            r_kmatch <= n_kmatch;
            r_await  <= n_await;
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_cnt    <= n_cnt;
        end
    end

endmodule

// ----- rtl/json_root_key_value_extractor.sv -----
// Streaming extractor for one key at the root of a JSON object. Bytes arrive one per transfer,
// with a transfer carrying i_msg_end closing each message. The block takes one byte every
// clock unless the input side stalls: each byte is registered, worked through the scanner and
// its results (at most one per byte, two only at message end) are written into an eight-entry
// result queue. The input side stalls only while that queue could overflow, i.e. when the
// output side is held off. Configuration (key, key length, value mode, capacity) goes through
// the plain write port and is to be written only while the block is idle; the block does not
// enforce this. KEY_BYTES bounds the stored key length, DEPTH_BITS the nesting counter.
module json_root_key_value_extractor #(
    parameter int KEY_BYTES  = 8,
    parameter int DEPTH_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [jrkv_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_byte_in,
    input  logic                               i_msg_end,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_has_item,
    output logic signed [jrkv_pkg::VALUE_W-1:0] o_value_int,
    output logic [jrkv_pkg::CHAR_W-1:0]        o_char_out,
    output logic                               o_found,
    output logic [jrkv_pkg::CAP_W-1:0]         o_item_count,
    output logic                               o_last
);

    localparam logic [jrkv_pkg::OUT_CNT_W:0] ROOM_LIMIT =
        (jrkv_pkg::OUT_CNT_W+1)'(jrkv_pkg::OUT_DEPTH - 2);

    logic [8*KEY_BYTES-1:0] r_key;
    jrkv_pkg::t_cfg         r_cfg;

    logic                              busy;
    logic                              push_a;
    logic                              push_b;
    jrkv_pkg::t_result                 res_a;
    jrkv_pkg::t_result                 res_b;
    jrkv_pkg::t_result                 res_out;
    logic [jrkv_pkg::OUT_CNT_W-1:0]    q_count;
    logic [jrkv_pkg::OUT_CNT_W:0]      q_need;
    logic                              in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key            <= '0;
            r_cfg.key_length <= jrkv_pkg::KEY_LENGTH_RST;
            r_cfg.value_mode <= jrkv_pkg::MODE_INT;
            r_cfg.capacity   <= jrkv_pkg::CAPACITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jrkv_pkg::CFG_KEY_BYTES:  r_key            <= i_cfg_wdata[8*KEY_BYTES-1:0];
                jrkv_pkg::CFG_KEY_LENGTH: r_cfg.key_length <= i_cfg_wdata[jrkv_pkg::KEY_LEN_W-1:0];
                jrkv_pkg::CFG_VALUE_MODE: r_cfg.value_mode <= i_cfg_wdata[1:0];
                jrkv_pkg::CFG_CAPACITY:   r_cfg.capacity   <= i_cfg_wdata[jrkv_pkg::CAP_W-1:0];
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    // worst case two results from the staged byte plus two from the next one
    assign q_need     = {1'b0, q_count} + (busy ? (jrkv_pkg::OUT_CNT_W+1)'(2) : '0);
    assign o_in_ready = (q_need <= ROOM_LIMIT);
    assign in_xfer    = i_in_valid && o_in_ready;

    jrkv_core #(
        .KEY_BYTES  (KEY_BYTES),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_xfer),
        .i_byte_in (i_byte_in),
        .i_msg_end (i_msg_end),
        .i_key     (r_key),
        .i_cfg     (r_cfg),
        .o_busy    (busy),
        .o_push_a  (push_a),
        .o_push_b  (push_b),
        .o_res_a   (res_a),
        .o_res_b   (res_b)
    );

    jrkv_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_push_b (push_b),
        .i_res_a  (res_a),
        .i_res_b  (res_b),
        .i_pop    (i_out_ready),
        .o_valid  (o_out_valid),
        .o_res    (res_out),
        .o_count  (q_count)
    );

    assign o_has_item   = res_out.has_item;
    assign o_value_int  = res_out.value_int;
    assign o_char_out   = res_out.char_out;
    assign o_found      = res_out.found;
    assign o_item_count = res_out.item_count;
    assign o_last       = res_out.last;

endmodule
